/* rtl/idl_pkg.sv */
// ----------------------------------------------------------------------------
// idl_pkg
// Shared types and constants for the indexed deque list.
// ----------------------------------------------------------------------------
package idl_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int POS_W         = 6;
    localparam int LEN_W         = 7;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int TDATA_IN_W    = 48;
    localparam int TDATA_OUT_W   = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_FRONT  = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_PLACE,
        S_DN_RD,
        S_DN_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   read_data;
        logic [LEN_W-1:0]    length;
        logic                is_empty;
    } result_t;

endpackage

/* rtl/idl_store.sv */
// ----------------------------------------------------------------------------
// idl_store
// Element storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module idl_store
    import idl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/idl_seq.sv */
// ----------------------------------------------------------------------------
// idl_seq
// Command sequencer: range checks, element shifting one slot at a time
// with the pointer increment and decrement, fill count and result formation.
// ----------------------------------------------------------------------------
module idl_seq
    import idl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  in_cmd,
    input  logic [POS_W-1:0]  in_pos,
    input  logic [DATA_W-1:0] in_value,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int LW   = (CW > LEN_W) ? CW : LEN_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [AW-1:0]     tgt_reg, tgt_next;
    logic [DATA_W-1:0] word_reg, word_next;
    status_t           status_reg, status_next;
    logic              rd_ok_reg, rd_ok_next;

    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic [AW-1:0]     pos_a;
    logic [AW-1:0]     cnt_a;
    logic              in_range;
    logic              full;
    logic [CW-1:0]     ptr_inc;
    logic [AW-1:0]     ptr_dec;
    logic [CW-1:0]     pos_inc;
    logic [LW-1:0]     cnt_w;
    cmd_t              cmd;

    assign pos_x    = CMPW'(in_pos);
    assign cnt_x    = CMPW'(count_reg);
    assign pos_a    = pos_x[AW-1:0];
    assign cnt_a    = count_reg[AW-1:0];
    assign in_range = pos_x < cnt_x;
    assign full     = count_reg == CW'(DEPTH);
    assign ptr_inc  = CW'(ptr_reg) + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign pos_inc  = CW'(pos_a) + 1'b1;
    assign cnt_w    = LW'(count_reg);
    assign cmd      = cmd_t'(in_cmd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        tgt_reg    <= tgt_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        tgt_next    = tgt_reg;
        word_next   = word_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = ptr_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = ptr_dec;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    word_next   = in_value;
                    status_next = STAT_DONE;
                    rd_ok_next  = 1'b0;
                    state_next  = S_FINISH;
                    case (cmd)
                        CMD_INSERT, CMD_FRONT, CMD_APPEND:
                        begin
                            if (cmd == CMD_INSERT && in_pos != '0 && !in_range)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                case (cmd)
                                    CMD_INSERT: tgt_next = pos_a;
                                    CMD_FRONT:  tgt_next = '0;
                                    default:    tgt_next = cnt_a;
                                endcase
                                ptr_next   = cnt_a;
                                state_next = (cnt_a == tgt_next) ? S_PLACE : S_UP_RD;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!in_range)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                ptr_next = pos_a;
                                if (pos_inc == count_reg)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                                else
                                begin
                                    state_next = S_DN_RD;
                                end
                            end
                        end
                        CMD_READ:
                        begin
                            if (!in_range)
                            begin
                                status_next = STAT_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_a;
                                rd_ok_next = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_dec;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_dec;
                state_next = (ptr_dec == tgt_reg) ? S_PLACE : S_UP_RD;
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg;
                mem_wdata  = word_reg;
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_DN_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_inc[AW-1:0];
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                ptr_next  = ptr_inc[AW-1:0];
                if (ptr_inc + 1'b1 == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.status    = status_reg;
        res.read_data = rd_ok_reg ? mem_rdata : '0;
        res.length    = cnt_w[LEN_W-1:0];
        res.is_empty  = (count_reg == '0);
    end

endmodule

/* rtl/indexed_deque_list.sv */
// ----------------------------------------------------------------------------
// indexed_deque_list
// Ordered list of up to DEPTH 32-bit words with positional insert, front
// insert, append, delete, read and clear.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transaction, m_* returns exactly one result
//   transaction per command, in order.
//   Words live in a single-port-write, single-port-read memory. Insert and
//   delete move the words behind the position one slot at a time through
//   the sequencer's pointer adder, with a read step and a write step per moved word.
//   Insert moves words with read and write steps from the end down to the
//   position, then places the new word; delete moves words with read and
//   write steps from the position up to the end and drops the length. Read,
//   clear, refused and unknown commands go straight to the final step, which
//   offers the result to the output register.
//   s_tready is high only while the sequencer is idle, so one command is in
//   work at a time; a finished result sits in the output register and the
//   next command is accepted while it waits.
//   If m_tready is low, the result holds in the output register and the
//   sequencer waits in its final step until that register frees up.
//   Reset empties the list and drops any pending result; stored words are
//   not cleared, only slots below the length are ever read.
// ----------------------------------------------------------------------------
module indexed_deque_list
    import idl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // cmd[2:0], position[8:3], value[40:9], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata    // status[1:0], read_data[33:2], length[40:34],
                                              // is_empty[41], zero pad
);

    localparam int AW = $clog2(DEPTH);

    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              m_tvalid_reg, m_tvalid_next;
    result_t           out_reg, out_next;

    idl_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_pos    (s_tdata[CMD_W+POS_W-1:CMD_W]),
        .in_value  (s_tdata[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    idl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg.is_empty, out_reg.length, out_reg.read_data,
                       out_reg.status};

endmodule

/* tb/sv/indexed_deque_list_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_deque_list_test
// Self-checking bench for the indexed deque list. A short table of directed
// commands covers the empty list, the range refusals, the
// unused command codes, clear, and the field extremes. Random phases follow
// that grow, fill, shrink and mix the list under sender gaps, receiver
// stalls and one long receiver hold-off. Every result transaction is
// compared field by field against the row's fixed result or an in-bench list model.
// ----------------------------------------------------------------------------
module indexed_deque_list_test;
    import idl_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam int DIRECTED_N  = 25;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 2 * DEPTH_DEFAULT + 40;

    typedef enum {OPS_MIX, OPS_FILL, OPS_GROW, OPS_SHRINK} op_mix_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        logic              has_fixed;
        result_t           fixed_result;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;    // cmd[2:0], position[8:3], value[40:9], zero pad
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;    // status[1:0], read_data[33:2], length[40:34],
                                        // is_empty[41], zero pad

    logic [DATA_W-1:0] list_words [0:DEPTH_DEFAULT-1];
    int                list_len;
    result_t           pending_results [$];
    int                error_count;
    int                snd_idle;
    int                rcv_stall;
    int                hold_requests;
    int                holds_started;
    int                hold_left;

    stim_row_t directed_rows [DIRECTED_N] = '{
        '{CMD_READ,   6'd0,  32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
        '{CMD_DELETE, 6'd0,  32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
        '{CMD_INSERT, 6'd5,  32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
        '{CMD_INSERT, 6'd0,  32'hFFFFFFFF, 1'b1, '{STAT_DONE,  32'd0, 7'd1, 1'b0}},
        '{CMD_FRONT,  6'd63, 32'h0,        1'b1, '{STAT_DONE,  32'd0, 7'd2, 1'b0}},
        '{CMD_APPEND, 6'd0,  32'hA5A5A5A5, 1'b1, '{STAT_DONE,  32'd0, 7'd3, 1'b0}},
        '{CMD_INSERT, 6'd2,  32'h5A5A5A5A, 1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_INSERT, 6'd4,  32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd4, 1'b0}},
        '{CMD_INSERT, 6'd63, 32'hFFFFFFFF, 1'b1, '{STAT_RANGE, 32'd0, 7'd4, 1'b0}},
        '{CMD_READ,   6'd0,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_READ,   6'd1,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_READ,   6'd2,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_READ,   6'd3,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_READ,   6'd63, 32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd4, 1'b0}},
        '{CMD_DELETE, 6'd1,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_READ,   6'd1,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_DELETE, 6'd2,  32'h0,        1'b0, '{STAT_DONE,  32'd0, 7'd0, 1'b0}},
        '{CMD_DELETE, 6'd2,  32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd2, 1'b0}},
        '{CMD_RSVD6,  6'd63, 32'hFFFFFFFF, 1'b1, '{STAT_DONE,  32'd0, 7'd2, 1'b0}},
        '{CMD_RSVD7,  6'd0,  32'h0,        1'b1, '{STAT_DONE,  32'd0, 7'd2, 1'b0}},
        '{CMD_CLEAR,  6'd0,  32'h0,        1'b1, '{STAT_DONE,  32'd0, 7'd0, 1'b1}},
        '{CMD_READ,   6'd0,  32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}},
        '{CMD_APPEND, 6'd0,  32'h12345678, 1'b1, '{STAT_DONE,  32'd0, 7'd1, 1'b0}},
        '{CMD_DELETE, 6'd0,  32'h0,        1'b1, '{STAT_DONE,  32'd0, 7'd0, 1'b1}},
        '{CMD_DELETE, 6'd63, 32'h0,        1'b1, '{STAT_RANGE, 32'd0, 7'd0, 1'b1}}
    };

    indexed_deque_list u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic open_gap(input int at, input logic [DATA_W-1:0] word);
        int k;
        for (k = list_len; k > at; k--)
            list_words[k] = list_words[k-1];
        list_words[at] = word;
        list_len++;
    endtask

    task automatic list_step(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] word, output result_t res);
        int k;
        bit full;
        full          = (list_len >= DEPTH_DEFAULT);
        res.status    = STAT_DONE;
        res.read_data = '0;
        case (op)
            CMD_INSERT:
                if (pos != 0 && int'(pos) >= list_len)
                    res.status = STAT_RANGE;
                else if (full)
                    res.status = STAT_FULL;
                else
                    open_gap(int'(pos), word);
            CMD_FRONT:
                if (full)
                    res.status = STAT_FULL;
                else
                    open_gap(0, word);
            CMD_APPEND:
                if (full)
                    res.status = STAT_FULL;
                else
                    open_gap(list_len, word);
            CMD_DELETE:
                if (int'(pos) >= list_len)
                    res.status = STAT_RANGE;
                else
                begin
                    for (k = int'(pos); k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                end
            CMD_READ:
                if (int'(pos) >= list_len)
                    res.status = STAT_RANGE;
                else
                    res.read_data = list_words[pos];
            CMD_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.length   = list_len[LEN_W-1:0];
        res.is_empty = (list_len == 0);
    endtask

    task automatic pick_command(input op_mix_t mix, output logic [CMD_W-1:0] op,
                                output logic [POS_W-1:0] pos, output logic [DATA_W-1:0] word);
        int r;
        int v;
        r = $urandom_range(99);
        case (mix)
            OPS_FILL:
                op = (r < 34) ? CMD_INSERT : (r < 67) ? CMD_FRONT : CMD_APPEND;
            OPS_GROW:
                op = (r < 30) ? CMD_INSERT : (r < 50) ? CMD_FRONT : (r < 75) ? CMD_APPEND :
                     (r < 85) ? CMD_READ : (r < 95) ? CMD_DELETE : (r < 99) ? CMD_RSVD6 :
                     CMD_CLEAR;
            OPS_SHRINK:
                op = (r < 40) ? CMD_DELETE : (r < 65) ? CMD_READ : (r < 75) ? CMD_INSERT :
                     (r < 82) ? CMD_FRONT : (r < 90) ? CMD_APPEND : (r < 95) ? CMD_RSVD7 :
                     CMD_CLEAR;
            default:
                op = (r < 20) ? CMD_INSERT : (r < 30) ? CMD_FRONT : (r < 42) ? CMD_APPEND :
                     (r < 67) ? CMD_DELETE : (r < 92) ? CMD_READ : (r < 95) ? CMD_RSVD6 :
                     (r < 97) ? CMD_RSVD7 : CMD_CLEAR;
        endcase
        if (list_len > 0 && (mix == OPS_FILL || $urandom_range(99) < 85))
            pos = POS_W'($urandom_range(list_len - 1));
        else if (mix == OPS_FILL)
            pos = '0;
        else
            pos = POS_W'($urandom_range(63));
        v = $urandom_range(9);
        word = (v == 0) ? 32'h0 : (v == 1) ? 32'hFFFFFFFF : $urandom;
    endtask

    task automatic send_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] word, input logic use_fixed,
                                input result_t fixed);
        result_t res;
        while ($urandom_range(99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, word, pos, op};
        do
            @(posedge clk);
        while (!s_tready);
        list_step(op, pos, word, res);
        pending_results.push_back(use_fixed ? fixed : res);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic run_phase(input int count, input op_mix_t mix, input int sidle,
                             input int rstall);
        logic [CMD_W-1:0]  op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] word;
        snd_idle  = sidle;
        rcv_stall = rstall;
        repeat (count)
        begin
            pick_command(mix, op, pos, word);
            send_command(op, pos, word, 1'b0, '0);
        end
        wait_drained();
    endtask

    // receiver side: random stalls plus a single long hold-off
    always @(posedge clk)
    begin
        if (hold_requests != holds_started)
        begin
            holds_started = hold_requests;
            hold_left     = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transaction, got %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                result_t exp_res;
                exp_res = pending_results.pop_front();
                if (m_tdata[1:0] !== exp_res.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, exp_res.status,
                             m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[33:2] !== exp_res.read_data)
                begin
                    $display("%0t: read_data expected %h, got %h", $time, exp_res.read_data,
                             m_tdata[33:2]);
                    error_count++;
                end
                if (m_tdata[40:34] !== exp_res.length)
                begin
                    $display("%0t: length expected %0d, got %0d", $time, exp_res.length,
                             m_tdata[40:34]);
                    error_count++;
                end
                if (m_tdata[41] !== exp_res.is_empty)
                begin
                    $display("%0t: is_empty expected %0d, got %0d", $time, exp_res.is_empty,
                             m_tdata[41]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        list_len      = 0;
        error_count   = 0;
        snd_idle      = 0;
        rcv_stall     = 0;
        hold_requests = 0;
        holds_started = 0;
        hold_left     = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].word,
                         directed_rows[i].has_fixed, directed_rows[i].fixed_result);
        wait_drained();

        run_phase(150, OPS_MIX, 0, 0);
        run_phase(72, OPS_FILL, 80, 0);
        run_phase(100, OPS_MIX, 0, 80);
        run_phase(130, OPS_SHRINK, 6, 6);
        hold_requests = hold_requests + 1;
        run_phase(100, OPS_GROW, 0, 0);
        run_phase(100, OPS_MIX, 6, 6);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("indexed_deque_list_test OK");
        else
            $display("indexed_deque_list_test NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout");
        $display("indexed_deque_list_test NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
rtl/idl_pkg.sv
rtl/idl_store.sv
rtl/idl_seq.sv
rtl/indexed_deque_list.sv
tb/sv/indexed_deque_list_test.sv
